// File: design/comf_pkg.sv
`timescale 1ns / 1ps
package comf_pkg;

  localparam logic [1:0] ACT_GATED  = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] REG_RTT_LIMIT = 2'd0;
  localparam logic [1:0] REG_MIN_SAMP  = 2'd1;
  localparam logic [1:0] REG_EMA_NUM   = 2'd2;
  localparam logic [1:0] REG_EMA_DEN   = 2'd3;

  localparam logic [31:0] RTT_LIMIT_RST = 32'd20000;
  localparam logic [3:0]  MIN_SAMP_RST  = 4'd5;
  localparam logic [7:0]  EMA_NUM_RST   = 8'd1;
  localparam logic [7:0]  EMA_DEN_RST   = 8'd10;

  localparam int DIG_W     = 8;
  localparam int DIV_W     = 80;
  localparam int DIV_STEPS = DIV_W / DIG_W;

  typedef struct packed {
    logic               vld;
    logic               lt;
    logic signed [63:0] val;
  } comf_link_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic shift;
  } comf_ctl_t;

endpackage

// File: design/comf_if.sv
`timescale 1ns / 1ps
interface comf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [63:0] offset_us;
  logic [31:0]        rtt_us;
  modport source (output valid, action, offset_us, rtt_us, input ready);
  modport sink (input valid, action, offset_us, rtt_us, output ready);
endinterface

interface comf_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               sync_valid;
  logic signed [63:0] median_offset_us;
  modport source (output valid, accepted, sync_valid, median_offset_us, input ready);
  modport sink (input valid, accepted, sync_valid, median_offset_us, output ready);
endinterface

// File: design/comf_cell.sv
`timescale 1ns / 1ps
module comf_cell
  import comf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  comf_ctl_t          ctl,
  input  logic signed [63:0] x,
  input  comf_link_t         lower,
  input  comf_link_t         upper,
  output comf_link_t         link
);

  logic               vld;
  logic signed [63:0] val;
  logic               lt;

  assign lt = !vld || (x < val);

  assign link.vld = vld;
  assign link.val = val;
  assign link.lt  = lt;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      vld <= 1'b0;
    end else if (ctl.load) begin
      if (lower.lt) begin
        vld <= lower.vld;
        val <= lower.val;
      end else if (lt) begin
        vld <= 1'b1;
        val <= x;
      end
    end else if (ctl.shift) begin
      vld <= upper.vld;
      val <= upper.val;
    end
  end

endmodule

// File: design/comf_div.sv
`timescale 1ns / 1ps
module comf_div
  import comf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic             busy;
  logic [3:0]       step;
  logic [DIV_W-1:0] acc;
  logic [7:0]       rem;
  logic [7:0]       rem_next;
  logic [DIG_W-1:0] qdig;

  always_comb begin
    logic [8:0] t;
    rem_next = rem;
    qdig     = '0;
    for (int i = 0; i < DIG_W; i++) begin
      t = {rem_next, acc[DIV_W-1-i]};
      if (t >= {1'b0, divisor}) begin
        rem_next          = 8'(t - {1'b0, divisor});
        qdig[DIG_W-1-i]   = 1'b1;
      end else begin
        rem_next = t[7:0];
      end
    end
  end

  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= dividend;
        rem  <= '0;
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        acc  <= {acc[DIV_W-DIG_W-1:0], qdig};
        rem  <= rem_next;
        step <= step + 4'd1;
        if (step == 4'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/clock_offset_median_filter.sv
`timescale 1ns / 1ps
// channel   dir  beat fields
// samples   in   action, offset_us, rtt_us
// results   out  accepted, sync_valid, median_offset_us
// apb       in   rtt_limit_us, min_samples_for_valid, ema_alpha_num, ema_alpha_den
//
// one item at a time; samples.ready is low from accept until its result is taken
// plain add or reject goes straight to done; an add that yields a median first loads
// the n held samples (ring read one entry a cycle into the sorting cells, then shift out)
// ema update: multiply, sum, sign, then the 8 bit per cycle divider over an 80 bit dividend
// rst clears the control state, window count, filter value and cell valid bits, and loads register reset values
module clock_offset_median_filter
  import comf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  comf_in_if.sink     samples,
  comf_out_if.source  results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW   = $clog2(WINDOW_DEPTH + 1);
  localparam int IW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CMPW = (CW > 4) ? CW : 4;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_SHIFT = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_NEG   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [31:0] rtt_limit;
  logic [3:0]  min_samp;
  logic [7:0]  ema_num;
  logic [7:0]  ema_den;

  logic [63:0]        ring [WINDOW_DEPTH];
  logic [IW-1:0]      wi;
  logic [CW-1:0]      cnt;
  logic signed [63:0] filt;
  logic               vflag;

  logic [CW-1:0]      k;
  logic [CW-1:0]      j;
  logic               feed;
  logic signed [63:0] rd_data;
  logic signed [63:0] lo;
  logic               acc_r;
  logic signed [63:0] off_r;
  logic signed [72:0] p1;
  logic signed [72:0] p2;
  logic signed [73:0] s;

  // apb
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_RTT_LIMIT: prdata = rtt_limit;
      REG_MIN_SAMP:  prdata = {28'd0, min_samp};
      REG_EMA_NUM:   prdata = {24'd0, ema_num};
      REG_EMA_DEN:   prdata = {24'd0, ema_den};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rtt_limit <= RTT_LIMIT_RST;
      min_samp  <= MIN_SAMP_RST;
      ema_num   <= EMA_NUM_RST;
      ema_den   <= EMA_DEN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RTT_LIMIT: rtt_limit <= pwdata;
        REG_MIN_SAMP:  min_samp  <= pwdata[3:0];
        REG_EMA_NUM:   ema_num   <= pwdata[7:0];
        REG_EMA_DEN:   ema_den   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic          in_fire;
  logic          is_add;
  logic          is_ema;
  logic [CW-1:0] cnt_inc;
  logic [3:0]    need;
  logic          go_sort;

  assign samples.ready = (state == S_IDLE) && !results.valid;
  assign in_fire = samples.valid && samples.ready;
  assign is_add  = ((samples.action == ACT_GATED) && (samples.rtt_us <= rtt_limit)) ||
                   ((samples.action == ACT_UPDATE) && !vflag);
  assign is_ema  = (samples.action == ACT_UPDATE) && vflag;
  assign cnt_inc = (cnt == CW'(WINDOW_DEPTH)) ? cnt : cnt + CW'(1);
  assign need    = (min_samp == 4'd0) ? 4'd1 : min_samp;
  assign go_sort = is_add && (CMPW'(cnt_inc) >= CMPW'(need));

  // sorting cells
  comf_ctl_t  ctl;
  comf_link_t links [WINDOW_DEPTH];

  assign ctl.clr   = in_fire && go_sort;
  assign ctl.load  = feed;
  assign ctl.shift = (state == S_SHIFT);

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    comf_link_t lower;
    comf_link_t upper;
    if (g == 0) begin : g_lo0
      assign lower = '0;
    end else begin : g_lon
      assign lower = links[g-1];
    end
    if (g == WINDOW_DEPTH - 1) begin : g_uplast
      assign upper = '0;
    end else begin : g_upn
      assign upper = links[g+1];
    end
    comf_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .x     (rd_data),
      .lower (lower),
      .upper (upper),
      .link  (links[g])
    );
  end

  // median: middle value for an odd count, else mean of the two middle values, truncated toward zero
  logic [CW-1:0]      half;
  logic signed [64:0] msum;
  logic signed [64:0] mhalf;
  logic signed [63:0] median;

  assign half  = cnt >> 1;
  assign msum  = 65'(lo) + 65'(links[0].val);
  assign mhalf = (msum >>> 1) + 65'(msum[64] & msum[0]);
  assign median = cnt[0] ? links[0].val : mhalf[63:0];

  // ema datapath
  logic signed [8:0]  numw;
  logic signed [8:0]  wgtw;
  logic               s_neg;
  logic [73:0]        s_mag;
  logic               div_start;
  logic               div_done;
  logic [DIV_W-1:0]   quot;
  logic signed [63:0] ema_res;

  assign numw  = $signed({1'b0, ema_num});
  assign wgtw  = $signed({1'b0, ema_den}) - $signed({1'b0, ema_num});
  assign s_neg = s[73];
  assign s_mag = s_neg ? 74'(-s) : 74'(s);
  assign div_start = (state == S_NEG);

  comf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({6'd0, s_mag}),
    .divisor  (ema_den),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (s_neg) begin
      ema_res = (quot > {16'd0, 64'h8000_0000_0000_0000}) ? 64'sh8000_0000_0000_0000
              : $signed(64'(-quot[63:0]));
    end else begin
      ema_res = (quot > {16'd0, 64'h7FFF_FFFF_FFFF_FFFF}) ? 64'sh7FFF_FFFF_FFFF_FFFF
              : $signed(quot[63:0]);
    end
  end

  // ring
  always_ff @(posedge clk) begin
    if (in_fire && is_add) begin
      ring[wi] <= samples.offset_us;
    end
    if ((state == S_LOAD) && (k < cnt)) begin
      rd_data <= $signed(ring[k[IW-1:0]]);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wi            <= '0;
      cnt           <= '0;
      filt          <= '0;
      vflag         <= 1'b0;
      feed          <= 1'b0;
      k             <= '0;
      j             <= '0;
      acc_r         <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      feed <= (state == S_LOAD) && (k < cnt);
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            off_r <= samples.offset_us;
            acc_r <= is_add || is_ema;
            state <= S_DONE;
            if (samples.action == ACT_CLEAR) begin
              wi    <= '0;
              cnt   <= '0;
              filt  <= '0;
              vflag <= 1'b0;
            end else if (is_add) begin
              wi  <= (wi == IW'(WINDOW_DEPTH - 1)) ? '0 : wi + IW'(1);
              cnt <= cnt_inc;
              if (go_sort) begin
                k     <= '0;
                state <= S_LOAD;
              end
            end else if (is_ema && (ema_den != 8'd0)) begin
              state <= S_MUL;
            end
          end
        end
        S_LOAD: begin
          if (k < cnt) begin
            k <= k + CW'(1);
          end else begin
            j     <= '0;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          j <= j + CW'(1);
          if (j == half - CW'(1)) begin
            lo <= links[0].val;
          end
          if (j == half) begin
            filt  <= median;
            vflag <= 1'b1;
            state <= S_DONE;
          end
        end
        S_MUL: begin
          p1    <= 73'(off_r) * 73'(numw);
          p2    <= 73'(filt) * 73'(wgtw);
          state <= S_SUM;
        end
        S_SUM: begin
          s     <= 74'(p1) + 74'(p2);
          state <= S_NEG;
        end
        S_NEG: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            filt  <= ema_res;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          results.valid <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      results.accepted         <= acc_r;
      results.sync_valid       <= vflag;
      results.median_offset_us <= vflag ? filt : 64'sd0;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |-> !results.valid)
    else $error("sample taken while result pending");

  a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.sync_valid |-> results.median_offset_us == 64'sd0)
    else $error("median nonzero while not synced");

  a_valid_has_samples: assert property (@(posedge clk) disable iff (rst)
    vflag |-> cnt != '0)
    else $error("sync valid with empty ring");

endmodule
